// ----- src/i2cra_pkg.sv -----
// shared types and constants for the i2c register access master
package i2cra_pkg;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;

  localparam logic [6:0] SLAVE_ADDR_RST = 7'd64;

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  reg_sel;
    logic [15:0] write_data;
    logic        sda_in;
  } in_word_t;

  typedef struct packed {
    logic        scl_level;
    logic        sda_level;
    logic        busy_res;
    logic        done_res;
    logic        ack_error;
    logic [15:0] read_data;
  } out_word_t;

  typedef enum logic [1:0] {
    REQ_TICK,
    REQ_READ,
    REQ_WRITE
  } req_e;

  typedef struct packed {
    req_e        req;
    logic [7:0]  reg_sel;
    logic [15:0] write_data;
    logic        sda_in;
  } tick_t;

  typedef enum logic [4:0] {
    PH_IDLE,
    PH_ST_SDA1,
    PH_ST_SCL1,
    PH_ST_SDA0,
    PH_ST_SCL0,
    PH_TX_SDA,
    PH_TX_SCLH,
    PH_TX_SCLL,
    PH_RA_SDA,
    PH_RA_SCLH,
    PH_RA_SCLL,
    PH_RX_REL,
    PH_RX_SCLH,
    PH_RX_SCLL,
    PH_SA_SDA,
    PH_SA_SCLH,
    PH_SA_SCLL,
    PH_SP_SDA0,
    PH_SP_SCLH,
    PH_SP_SDA1
  } phase_e;

endpackage

// ----- src/i2cra_front.sv -----
// front end: classifies incoming ticks and queues them for the sequencer
module i2cra_front import i2cra_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_word_t in_word_i,
  output logic     q_valid_o,
  input  logic     q_pop_i,
  output tick_t    q_word_o
);

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  tick_t            entry_q [QUEUE_DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  tick_t            cls;
  logic             push, pop;

  // op value three behaves as a plain tick
  always_comb begin
    cls.reg_sel    = in_word_i.reg_sel;
    cls.write_data = in_word_i.write_data;
    cls.sda_in     = in_word_i.sda_in;
    case (in_word_i.op)
      OP_READ:  cls.req = REQ_READ;
      OP_WRITE: cls.req = REQ_WRITE;
      default:  cls.req = REQ_TICK;
    endcase
  end

  assign in_stall_o = (count_q == CntW'(QUEUE_DEPTH));
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = q_pop_i && (count_q != '0);
  assign q_valid_o  = (count_q != '0);
  assign q_word_o   = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= cls;
    end
  end

endmodule

// ----- src/i2cra_back.sv -----
// back end: i2c pin step sequencer with registered result word
module i2cra_back import i2cra_pkg::*; #(
  parameter int unsigned DATA_BYTES = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [6:0] slave_addr_i,
  input  logic       q_valid_i,
  output logic       q_pop_o,
  input  tick_t      q_word_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_word_t  out_word_o
);

  localparam int unsigned NBytes = (DATA_BYTES < 1) ? 1 : ((DATA_BYTES > 4) ? 4 : DATA_BYTES);
  localparam logic [3:0] WrLast = 4'(2 + NBytes);
  localparam logic [3:0] RdLast = 4'(3 + NBytes);
  localparam logic [2:0] NbW    = 3'(NBytes);

  phase_e      phase_q, phase_d;
  logic [3:0]  bit_q, bit_d;
  logic [7:0]  shift_q, shift_d;
  logic [2:0]  byte_q, byte_d;
  logic        is_read_q;
  logic [7:0]  reg_q;
  logic [15:0] data_q;
  logic [15:0] rx_q, rx_d;
  logic        scl_q, scl_d;
  logic        sda_q, sda_d;
  logic        done, err;

  logic        out_valid_q;
  out_word_t   out_q;

  // values seen by this step, a request from idle restarts everything
  logic        start;
  phase_e      ph_e;
  logic        rd_e;
  logic [7:0]  reg_e;
  logic [15:0] data_e;
  logic [15:0] rx_e;
  logic [2:0]  byte_e;
  logic [3:0]  bit_e;
  logic [7:0]  shift_e;
  logic [2:0]  byte_nx;
  logic [3:0]  bit_nx;
  logic [2:0]  tx_idx;
  logic [7:0]  tx_val;
  logic        tx_more;
  logic        rx_last;
  logic [2:0]  d_idx, k_idx;

  assign q_pop_o = q_valid_i && (!out_valid_q || !out_stall_i);

  assign start  = (phase_q == PH_IDLE) &&
                  (q_word_i.req == REQ_READ || q_word_i.req == REQ_WRITE);
  assign ph_e    = start ? PH_ST_SDA1 : phase_q;
  assign rd_e    = start ? (q_word_i.req == REQ_READ) : is_read_q;
  assign reg_e   = start ? q_word_i.reg_sel : reg_q;
  assign data_e  = start ? q_word_i.write_data : data_q;
  assign rx_e    = (start && q_word_i.req == REQ_READ) ? '0 : rx_q;
  assign byte_e  = start ? '0 : byte_q;
  assign bit_e   = start ? '0 : bit_q;
  assign shift_e = start ? '0 : shift_q;

  assign byte_nx = byte_e + 3'd1;
  assign bit_nx  = bit_e + 4'd1;
  assign rx_last = ({1'b0, byte_e} >= RdLast);
  assign tx_more = rd_e ? (byte_nx < 3'd2) : ({1'b0, byte_nx} < WrLast);

  // byte to send: address+W, register, then address+R or data msb first
  assign tx_idx = (ph_e == PH_RA_SCLL) ? byte_nx : byte_e;
  assign d_idx  = tx_idx - 3'd2;
  assign k_idx  = NbW - 3'd1 - d_idx;
  always_comb begin
    if (tx_idx == 3'd0) begin
      tx_val = {slave_addr_i, 1'b0};
    end else if (tx_idx == 3'd1) begin
      tx_val = reg_e;
    end else if (rd_e) begin
      tx_val = {slave_addr_i, 1'b1};
    end else if (d_idx >= NbW) begin
      tx_val = '0;
    end else if (k_idx == 3'd0) begin
      tx_val = data_e[7:0];
    end else if (k_idx == 3'd1) begin
      tx_val = data_e[15:8];
    end else begin
      tx_val = '0;
    end
  end

  // next phase
  always_comb begin
    case (ph_e)
      PH_ST_SDA1: phase_d = PH_ST_SCL1;
      PH_ST_SCL1: phase_d = PH_ST_SDA0;
      PH_ST_SDA0: phase_d = PH_ST_SCL0;
      PH_ST_SCL0: phase_d = PH_TX_SDA;
      PH_TX_SDA:  phase_d = PH_TX_SCLH;
      PH_TX_SCLH: phase_d = PH_TX_SCLL;
      PH_TX_SCLL: phase_d = (bit_nx >= 4'd8) ? PH_RA_SDA : PH_TX_SDA;
      PH_RA_SDA:  phase_d = PH_RA_SCLH;
      PH_RA_SCLH: phase_d = PH_RA_SCLL;
      PH_RA_SCLL: begin
        if (shift_e[0]) begin
          phase_d = PH_IDLE;
        end else if (tx_more) begin
          phase_d = PH_TX_SDA;
        end else if (!rd_e) begin
          phase_d = PH_SP_SDA0;
        end else if (byte_nx == 3'd2) begin
          phase_d = PH_ST_SDA1;
        end else begin
          phase_d = PH_RX_REL;
        end
      end
      PH_RX_REL:  phase_d = PH_RX_SCLH;
      PH_RX_SCLH: phase_d = PH_RX_SCLL;
      PH_RX_SCLL: phase_d = (bit_nx >= 4'd8) ? PH_SA_SDA : PH_RX_SCLH;
      PH_SA_SDA:  phase_d = PH_SA_SCLH;
      PH_SA_SCLH: phase_d = PH_SA_SCLL;
      PH_SA_SCLL: phase_d = rx_last ? PH_SP_SDA0 : PH_RX_REL;
      PH_SP_SDA0: phase_d = PH_SP_SCLH;
      PH_SP_SCLH: phase_d = PH_SP_SDA1;
      default:    phase_d = PH_IDLE;
    endcase
  end

  // pin steps and datapath
  always_comb begin
    scl_d   = scl_q;
    sda_d   = sda_q;
    bit_d   = bit_e;
    shift_d = shift_e;
    byte_d  = byte_e;
    rx_d    = rx_e;
    done    = 1'b0;
    err     = 1'b0;
    case (ph_e)
      PH_ST_SDA1: sda_d = 1'b1;
      PH_ST_SCL1: scl_d = 1'b1;
      PH_ST_SDA0: sda_d = 1'b0;
      PH_ST_SCL0: begin
        scl_d   = 1'b0;
        shift_d = tx_val;
        bit_d   = '0;
      end
      PH_TX_SDA:  sda_d = shift_e[7];
      PH_TX_SCLH: scl_d = 1'b1;
      PH_TX_SCLL: begin
        scl_d   = 1'b0;
        shift_d = {shift_e[6:0], 1'b0};
        bit_d   = bit_nx;
      end
      PH_RA_SDA:  sda_d = 1'b1;
      PH_RA_SCLH: begin
        scl_d   = 1'b1;
        shift_d = {7'd0, q_word_i.sda_in};
      end
      PH_RA_SCLL: begin
        scl_d = 1'b0;
        if (shift_e[0]) begin
          // nack: abort without stop
          done = 1'b1;
          err  = 1'b1;
          if (rd_e) begin
            rx_d = '0;
          end
        end else begin
          byte_d = byte_nx;
          if (tx_more) begin
            shift_d = tx_val;
            bit_d   = '0;
          end
        end
      end
      PH_RX_REL: begin
        sda_d   = 1'b1;
        bit_d   = '0;
        shift_d = '0;
      end
      PH_RX_SCLH: begin
        scl_d   = 1'b1;
        shift_d = {shift_e[6:0], q_word_i.sda_in};
      end
      PH_RX_SCLL: begin
        scl_d = 1'b0;
        bit_d = bit_nx;
        if (bit_nx >= 4'd8) begin
          rx_d   = {rx_e[7:0], shift_e};
          byte_d = byte_nx;
        end
      end
      PH_SA_SDA:  sda_d = rx_last;
      PH_SA_SCLH: scl_d = 1'b1;
      PH_SA_SCLL: scl_d = 1'b0;
      PH_SP_SDA0: sda_d = 1'b0;
      PH_SP_SCLH: scl_d = 1'b1;
      PH_SP_SDA1: begin
        sda_d = 1'b1;
        done  = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      bit_q     <= '0;
      shift_q   <= '0;
      byte_q    <= '0;
      is_read_q <= 1'b0;
      reg_q     <= '0;
      data_q    <= '0;
      rx_q      <= '0;
      scl_q     <= 1'b1;
      sda_q     <= 1'b1;
    end else if (q_pop_o) begin
      phase_q   <= phase_d;
      bit_q     <= bit_d;
      shift_q   <= shift_d;
      byte_q    <= byte_d;
      is_read_q <= rd_e;
      reg_q     <= reg_e;
      data_q    <= data_e;
      rx_q      <= rx_d;
      scl_q     <= scl_d;
      sda_q     <= sda_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (q_pop_o) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      out_q.scl_level <= scl_d;
      out_q.sda_level <= sda_d;
      out_q.busy_res  <= (phase_d != PH_IDLE);
      out_q.done_res  <= done;
      out_q.ack_error <= err;
      out_q.read_data <= rx_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.done_res && out_q.busy_res))
    else $error("done word reports busy");

  a_err_with_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.ack_error) |-> out_q.done_res)
    else $error("ack error without done");

  a_idle_tick_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop_o && phase_q == PH_IDLE && q_word_i.req == REQ_TICK) |=>
      (!out_q.busy_res && !out_q.done_res && out_q.scl_level == $past(scl_q)
       && out_q.sda_level == $past(sda_q)))
    else $error("idle tick changed bus or status");

  a_bit_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bit_q <= 4'd8)
    else $error("bit counter out of range");

  a_nack_abort_pins: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.ack_error) |-> (!out_q.scl_level && out_q.sda_level))
    else $error("abort left bus in wrong state");

endmodule

// ----- src/i2c_master_register_access.sv -----
// top level of the i2c master register read/write sequencer
//
// Each input word is one bus tick: the sampled SDA level and, while the
// master is idle, an optional read or write request for a 16-bit register.
// Each accepted word gives exactly one output word with the SCL/SDA drive
// levels after that tick's pin step, busy, done, ack error and the word
// received so far.
// Both channels use valid/stall; a word moves when valid is high and stall
// is low. The slave address register is written through cfg_we_i and resets
// to 64; the user must write it only while the master is idle, as the
// block itself does not enforce this. An accepted input word passes
// through the two-entry tick queue, then the sequencer and its output
// register. While the output is not stalled, throughput is one word per
// cycle, set by the sequencer, which makes one pin step per cycle.
// While the output is stalled a valid output word holds, the queue fills and
// in_stall_o rises once both entries are taken.
// After reset the bus is released (SCL and SDA high), the sequencer is idle
// and the queue is empty.
module i2c_master_register_access import i2cra_pkg::*; #(
  parameter int unsigned DATA_BYTES = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [6:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_word_t   in_word_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_word_t  out_word_o
);

  logic [6:0] slave_addr_q;
  logic       q_valid;
  logic       q_pop;
  tick_t      q_word;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_addr_q <= SLAVE_ADDR_RST;
    end else if (cfg_we_i) begin
      slave_addr_q <= cfg_wdata_i;
    end
  end

  i2cra_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .q_valid_o  (q_valid),
    .q_pop_i    (q_pop),
    .q_word_o   (q_word)
  );

  i2cra_back #(
    .DATA_BYTES (DATA_BYTES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .slave_addr_i (slave_addr_q),
    .q_valid_i    (q_valid),
    .q_pop_o      (q_pop),
    .q_word_i     (q_word),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_word_o   (out_word_o)
  );

endmodule
